### rtl/tdt_pkg.sv
package tdt_pkg;

    localparam int TABLE_ENTRIES   = 16;
    localparam int EMA_DENOMINATOR = 4;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int EMA_W = $clog2(EMA_DENOMINATOR + 1);

    // fixed field widths
    localparam int ADDR_W    = 48;
    localparam int TIME_W    = 32;
    localparam int SIG_W     = 8;
    localparam int VENDOR_W  = 8;
    localparam int CLASS_W   = 4;
    localparam int VIA_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int WEIGHT_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [WEIGHT_W-1:0]      WEIGHT_RESET  = 3'd1;
    localparam logic [TIME_W-1:0]        TIMEOUT_RESET = 32'd30000;
    localparam logic signed [SIG_W-1:0]  SIG_FLOOR     = -8'sd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_WEIGHT   = 2'd0,
        CFG_IDLE_TIMEOUT = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_BEST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_req;
        logic scan_init;
        logic scan_step;
        logic write_rec;
        logic best_init;
        logic best_step;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
    } t_sts;

endpackage

### rtl/tdt_ctrl.sv
module tdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  tdt_pkg::t_sts i_sts,
    output tdt_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import tdt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req  = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // match, free slot, oldest entry, or expiry
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_rec = 1'b1;
                o_cmd.best_init = 1'b1;
                n_state         = S_BEST;
            end
            S_BEST: begin
                o_cmd.best_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/tdt_dp.sv
module tdt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tdt_pkg::t_cmd                        i_cmd,
    output tdt_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_valid,
    input  logic [tdt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tdt_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                 i_operation,
    input  logic [tdt_pkg::TIME_W-1:0]           i_now_ms,
    input  logic [tdt_pkg::ADDR_W-1:0]           i_station_addr,
    input  logic signed [tdt_pkg::SIG_W-1:0]     i_signal_dbm,
    input  logic [tdt_pkg::VENDOR_W-1:0]         i_vendor_id,
    input  logic [tdt_pkg::CLASS_W-1:0]          i_gear_class,
    input  logic [tdt_pkg::VIA_W-1:0]            i_seen_via,
    output logic [tdt_pkg::SLOT_W-1:0]           o_slot_used,
    output logic                                 o_matched_existing,
    output logic                                 o_evicted,
    output logic [tdt_pkg::COUNT_W-1:0]          o_expired_count,
    output logic [tdt_pkg::COUNT_W-1:0]          o_active_count,
    output logic                                 o_best_valid,
    output logic [tdt_pkg::SLOT_W-1:0]           o_best_slot,
    output logic signed [tdt_pkg::SIG_W-1:0]     o_best_signal,
    output logic [tdt_pkg::ADDR_W-1:0]           o_best_addr,
    output logic [tdt_pkg::VENDOR_W-1:0]         o_best_vendor,
    output logic [tdt_pkg::CLASS_W-1:0]          o_best_class,
    output logic [tdt_pkg::TIME_W-1:0]           o_last_hit_ms
);
    import tdt_pkg::*;

    localparam int SUM_W = SIG_W + EMA_W + 2;
    localparam logic signed [SUM_W-1:0] EMA_DEN_S = SUM_W'(EMA_DENOMINATOR);

    // configuration
    logic [WEIGHT_W-1:0] r_weight;
    logic [TIME_W-1:0]   r_timeout;

    // table
    logic                     r_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        r_addr  [TABLE_ENTRIES];
    logic signed [SIG_W-1:0]  r_sig   [TABLE_ENTRIES];
    logic [TIME_W-1:0]        r_first [TABLE_ENTRIES];
    logic [TIME_W-1:0]        r_last  [TABLE_ENTRIES];
    logic [VENDOR_W-1:0]      r_vendor[TABLE_ENTRIES];
    logic [CLASS_W-1:0]       r_class [TABLE_ENTRIES];
    logic [VIA_W-1:0]         r_via   [TABLE_ENTRIES];
    logic [TIME_W-1:0]        r_last_hit;

    // held request
    logic                     r_tick;
    logic [TIME_W-1:0]        r_now;
    logic [ADDR_W-1:0]        r_req_addr;
    logic signed [SIG_W-1:0]  r_req_sig;
    logic [VENDOR_W-1:0]      r_req_vendor;
    logic [CLASS_W-1:0]       r_req_class;
    logic [VIA_W-1:0]         r_req_via;

    // scan state
    logic [IDX_W-1:0]         r_idx;
    logic                     r_found;
    logic [IDX_W-1:0]         r_mslot;
    logic signed [SIG_W-1:0]  r_old_sig;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_fslot;
    logic [TIME_W-1:0]        r_oldest;
    logic [IDX_W-1:0]         r_oslot;
    logic [CNT_W-1:0]         r_expired;

    // result
    logic [IDX_W-1:0]         r_slot;
    logic                     r_matched;
    logic                     r_evicted;
    logic [CNT_W-1:0]         r_active;
    logic                     r_best_valid;
    logic [IDX_W-1:0]         r_best_slot;
    logic signed [SIG_W-1:0]  r_best_sig;
    logic [ADDR_W-1:0]        r_best_addr;
    logic [VENDOR_W-1:0]      r_best_vendor;
    logic [CLASS_W-1:0]       r_best_class;

    // entry under the scan pointer
    logic                     e_valid;
    logic [ADDR_W-1:0]        e_addr;
    logic signed [SIG_W-1:0]  e_sig;
    logic [TIME_W-1:0]        e_last;
    logic [VENDOR_W-1:0]      e_vendor;
    logic [CLASS_W-1:0]       e_class;
    logic                     expire_hit;

    logic [IDX_W-1:0]         new_slot;
    logic [IDX_W-1:0]         wr_slot;
    logic                     rec_write;

    logic signed [EMA_W:0]    w_new;
    logic signed [EMA_W:0]    w_old;
    logic signed [SUM_W-1:0]  ema_sum;
    logic signed [SUM_W-1:0]  ema_quo;
    logic signed [SIG_W-1:0]  ema_sig;

    assign e_valid  = r_valid[r_idx];
    assign e_addr   = r_addr[r_idx];
    assign e_sig    = r_sig[r_idx];
    assign e_last   = r_last[r_idx];
    assign e_vendor = r_vendor[r_idx];
    assign e_class  = r_class[r_idx];

    assign expire_hit = e_valid && ((r_now - e_last) > r_timeout);

    assign o_sts.idx_last = (r_idx == IDX_W'(TABLE_ENTRIES - 1));

    assign new_slot  = r_free_found ? r_fslot : r_oslot;
    assign wr_slot   = r_found ? r_mslot : new_slot;
    assign rec_write = i_cmd.write_rec && !r_tick;

    // clamp weight to the denominator, truncate toward zero
    always_comb begin
        if (int'(r_weight) > EMA_DENOMINATOR) begin
            w_new = (EMA_W + 1)'(EMA_DENOMINATOR);
        end else begin
            w_new = (EMA_W + 1)'(r_weight);
        end
        w_old   = (EMA_W + 1)'(EMA_DENOMINATOR) - w_new;
        ema_sum = SUM_W'(r_req_sig) * SUM_W'(w_new) + SUM_W'(r_old_sig) * SUM_W'(w_old);
        ema_quo = ema_sum / EMA_DEN_S;
        ema_sig = ema_quo[SIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= WEIGHT_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_EMA_WEIGHT) begin
                r_weight <= i_cfg_data[WEIGHT_W-1:0];
            end else if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                r_timeout <= i_cfg_data[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_last_hit <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cmd.scan_step && r_tick && expire_hit) begin
                r_valid[r_idx] <= 1'b0;
            end else if (rec_write) begin
                r_valid[wr_slot] <= 1'b1;
            end
            if (rec_write) begin
                r_last_hit <= r_now;
            end
            if (i_cmd.scan_init || i_cmd.best_init) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step || i_cmd.best_step) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_write) begin
            if (r_found) begin
                r_sig[wr_slot]  <= ema_sig;
                r_last[wr_slot] <= r_now;
            end else begin
                r_addr[wr_slot]   <= r_req_addr;
                r_sig[wr_slot]    <= r_req_sig;
                r_first[wr_slot]  <= r_now;
                r_last[wr_slot]   <= r_now;
                r_vendor[wr_slot] <= r_req_vendor;
                r_class[wr_slot]  <= r_req_class;
                r_via[wr_slot]    <= r_req_via;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_tick       <= (i_operation == OP_TICK);
            r_now        <= i_now_ms;
            r_req_addr   <= i_station_addr;
            r_req_sig    <= i_signal_dbm;
            r_req_vendor <= i_vendor_id;
            r_req_class  <= i_gear_class;
            r_req_via    <= i_seen_via;
            r_slot       <= '0;
            r_matched    <= 1'b0;
            r_evicted    <= 1'b0;
            r_expired    <= '0;
        end
        if (i_cmd.scan_init) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_mslot      <= '0;
            r_fslot      <= '0;
            r_oslot      <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_tick) begin
                if (expire_hit) begin
                    r_expired <= r_expired + 1'b1;
                end
            end else begin
                if (!r_found && e_valid && (e_addr == r_req_addr)) begin
                    r_found   <= 1'b1;
                    r_mslot   <= r_idx;
                    r_old_sig <= e_sig;
                end
                if (!r_free_found && !e_valid) begin
                    r_free_found <= 1'b1;
                    r_fslot      <= r_idx;
                end
                // raw compare, lowest slot wins ties
                if ((r_idx == '0) || (e_last < r_oldest)) begin
                    r_oldest <= e_last;
                    r_oslot  <= r_idx;
                end
            end
        end
        if (rec_write) begin
            r_slot    <= wr_slot;
            r_matched <= r_found;
            r_evicted <= !r_found && !r_free_found;
        end
        if (i_cmd.best_init) begin
            r_active      <= '0;
            r_best_valid  <= 1'b0;
            r_best_sig    <= SIG_FLOOR;
            r_best_slot   <= '0;
            r_best_addr   <= '0;
            r_best_vendor <= '0;
            r_best_class  <= '0;
        end
        if (i_cmd.best_step && e_valid) begin
            r_active <= r_active + 1'b1;
            if (e_sig > r_best_sig) begin
                r_best_valid  <= 1'b1;
                r_best_sig    <= e_sig;
                r_best_slot   <= r_idx;
                r_best_addr   <= e_addr;
                r_best_vendor <= e_vendor;
                r_best_class  <= e_class;
            end
        end
    end

    assign o_slot_used        = SLOT_W'(r_slot);
    assign o_matched_existing = r_matched;
    assign o_evicted          = r_evicted;
    assign o_expired_count    = COUNT_W'(r_expired);
    assign o_active_count     = COUNT_W'(r_active);
    assign o_best_valid       = r_best_valid;
    assign o_best_slot        = SLOT_W'(r_best_slot);
    assign o_best_signal      = r_best_sig;
    assign o_best_addr        = r_best_addr;
    assign o_best_vendor      = r_best_vendor;
    assign o_best_class       = r_best_class;
    assign o_last_hit_ms      = r_last_hit;

endmodule

### rtl/tracked_device_table_lru.sv
// Table of sighted transmitters keyed by 48-bit address, with least-recently-seen
// eviction and idle expiry. A record request updates the matching entry (smoothed
// strength, new last-seen time) or fills the lowest free slot, evicting the entry
// with the smallest raw last-seen time when the table is full; a tick request
// clears entries whose wrapping age exceeds idle_timeout_ms. Each request yields
// one result with the active count and the strongest entry. The table is read
// through a single entry port that a sequencer sweeps twice per request (once to
// match, find space or expire, once to count and pick the strongest), so the result
// is offered once both sweeps are done. The next request is taken the cycle after
// the result has been delivered, so no new request is accepted while one is in
// progress, and any output stall delays the next one further.
// Configuration is always ready and must be written while idle.
module tracked_device_table_lru (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tdt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tdt_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic [tdt_pkg::TIME_W-1:0]           i_now_ms,
    input  logic [tdt_pkg::ADDR_W-1:0]           i_station_addr,
    input  logic signed [tdt_pkg::SIG_W-1:0]     i_signal_dbm,
    input  logic [tdt_pkg::VENDOR_W-1:0]         i_vendor_id,
    input  logic [tdt_pkg::CLASS_W-1:0]          i_gear_class,
    input  logic [tdt_pkg::VIA_W-1:0]            i_seen_via,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tdt_pkg::SLOT_W-1:0]           o_slot_used,
    output logic                                 o_matched_existing,
    output logic                                 o_evicted,
    output logic [tdt_pkg::COUNT_W-1:0]          o_expired_count,
    output logic [tdt_pkg::COUNT_W-1:0]          o_active_count,
    output logic                                 o_best_valid,
    output logic [tdt_pkg::SLOT_W-1:0]           o_best_slot,
    output logic signed [tdt_pkg::SIG_W-1:0]     o_best_signal,
    output logic [tdt_pkg::ADDR_W-1:0]           o_best_addr,
    output logic [tdt_pkg::VENDOR_W-1:0]         o_best_vendor,
    output logic [tdt_pkg::CLASS_W-1:0]          o_best_class,
    output logic [tdt_pkg::TIME_W-1:0]           o_last_hit_ms
);
    import tdt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tdt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_now_ms           (i_now_ms),
        .i_station_addr     (i_station_addr),
        .i_signal_dbm       (i_signal_dbm),
        .i_vendor_id        (i_vendor_id),
        .i_gear_class       (i_gear_class),
        .i_seen_via         (i_seen_via),
        .o_slot_used        (o_slot_used),
        .o_matched_existing (o_matched_existing),
        .o_evicted          (o_evicted),
        .o_expired_count    (o_expired_count),
        .o_active_count     (o_active_count),
        .o_best_valid       (o_best_valid),
        .o_best_slot        (o_best_slot),
        .o_best_signal      (o_best_signal),
        .o_best_addr        (o_best_addr),
        .o_best_vendor      (o_best_vendor),
        .o_best_class       (o_best_class),
        .o_last_hit_ms      (o_last_hit_ms)
    );

endmodule
